[src/assert_macros.svh]
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds whenever the antecedent is seen, same cycle
`define EPSE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// property holds in the cycle after the antecedent
`define EPSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/epse_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epse_pkg
// types, codes, limits and step tables of the pwm setting editor
// ----------------------------------------------------------------------------
package epse_pkg;

	typedef logic [19:0] freq_t;
	typedef logic [6:0]  duty_t;
	typedef logic [12:0] dead_t;
	typedef logic [1:0]  func_t;
	typedef logic [1:0]  mode_t;
	typedef logic [7:0]  half_count_t;

	// event kinds
	localparam func_t FUNC_ENCODER = 2'd0;
	localparam func_t FUNC_BUTTON  = 2'd1;
	localparam func_t FUNC_SELECT  = 2'd2;

	// edit modes
	localparam mode_t MODE_FREQ = 2'd0;
	localparam mode_t MODE_DUTY = 2'd1;
	localparam mode_t MODE_DEAD = 2'd2;

	// limits
	localparam freq_t FREQ_MAX   = 20'd1000000;
	localparam freq_t FREQ_MIN   = 20'd10;
	localparam duty_t DUTY_MAX   = 7'd99;
	localparam duty_t DUTY_MIN   = 7'd1;
	localparam dead_t DEAD_MAX   = 13'd6000;
	localparam dead_t DEAD_FLOOR = 13'd5;

	// reset values per bank
	localparam freq_t RST_FREQ_B0 = 20'd60100;
	localparam freq_t RST_FREQ_B1 = 20'd59100;
	localparam duty_t RST_DUTY    = 7'd50;
	localparam dead_t RST_DEAD_B0 = 13'd150;
	localparam dead_t RST_DEAD_B1 = 13'd200;

	// preset values per bank
	localparam freq_t PRE_FREQ_B0 = 20'd60000;
	localparam freq_t PRE_FREQ_B1 = 20'd59000;
	localparam duty_t PRE_DUTY    = 7'd50;
	localparam dead_t PRE_DEAD_B0 = 13'd200;
	localparam dead_t PRE_DEAD_B1 = 13'd150;

	// step sizes: fine wins over coarse
	function automatic logic [9:0] freq_step(input logic fine, input logic coarse);
		if (fine)
			return 10'd10;
		if (coarse)
			return 10'd1000;
		return 10'd100;
	endfunction

	function automatic logic [3:0] duty_step(input logic fine, input logic coarse);
		if (fine)
			return 4'd5;
		if (coarse)
			return 4'd10;
		return 4'd1;
	endfunction

	function automatic logic [6:0] dead_step(input logic fine, input logic coarse);
		if (fine)
			return 7'd50;
		if (coarse)
			return 7'd100;
		return 7'd5;
	endfunction

endpackage
`default_nettype wire

[src/epse_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epse_in_if / epse_out_if
// valid/ready channels for editor events and reported settings
// ----------------------------------------------------------------------------
interface epse_in_if;
	import epse_pkg::*;

	logic        valid;
	logic        ready;
	func_t       func;
	half_count_t encoder_half_count;
	logic        fine_key_held;
	logic        coarse_key_held;
	logic        preset_key_held;

	modport source (
		output valid, func, encoder_half_count, fine_key_held, coarse_key_held,
			preset_key_held,
		input  ready
	);
	modport sink (
		input  valid, func, encoder_half_count, fine_key_held, coarse_key_held,
			preset_key_held,
		output ready
	);
endinterface

interface epse_out_if;
	import epse_pkg::*;

	logic  valid;
	logic  ready;
	freq_t out_frequency;
	duty_t out_duty;
	dead_t out_dead_time;
	logic  out_bank;
	mode_t out_mode;
	logic  reload;

	modport source (
		output valid, out_frequency, out_duty, out_dead_time, out_bank, out_mode, reload,
		input  ready
	);
	modport sink (
		input  valid, out_frequency, out_duty, out_dead_time, out_bank, out_mode, reload,
		output ready
	);
endinterface
`default_nettype wire

[src/encoder_pwm_setting_editor_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_pwm_setting_editor_core
// two-bank pwm setting editor driven by encoder, button and bank select events
// ----------------------------------------------------------------------------
// channel    dir   contents
// events     in    func, encoder_half_count, fine/coarse/preset key levels
// settings   out   active frequency, duty, dead time, bank, mode, reload
//
// one event per cycle sustained while settings.ready is high; an accepted request
// is held in the input register, then in the result register, where it is taken
// the edit logic is one add and compare per field plus clamp selection
// arst_n puts both banks, active bank, mode and last half-count to reset values
// a stalled result holds the result register; one more request fits while the input
// register is empty, once it holds a request events.ready drops in the same cycle
// ----------------------------------------------------------------------------
module encoder_pwm_setting_editor_core (
	input  wire        clk,
	input  wire        arst_n,
	epse_in_if.sink    events,
	epse_out_if.source settings
);
	import epse_pkg::*;

	// input register
	logic        valid_s1;
	func_t       func_s1;
	half_count_t half_count_s1;
	logic        fine_s1;
	logic        coarse_s1;
	logic        preset_s1;

	// editor state
	freq_t       freq_q [2];
	duty_t       duty_q [2];
	dead_t       dead_q [2];
	logic        bank_q;
	mode_t       mode_q;
	half_count_t last_q;

	// result register
	logic        out_valid_q;
	freq_t       out_freq_q;
	duty_t       out_duty_q;
	dead_t       out_dead_q;
	logic        out_bank_q;
	mode_t       out_mode_q;
	logic        out_reload_q;

	// next values
	freq_t       freq_nxt [2];
	duty_t       duty_nxt [2];
	dead_t       dead_nxt [2];
	logic        bank_nxt;
	mode_t       mode_nxt;
	half_count_t last_nxt;
	logic        reload_nxt;

	// edit datapath
	freq_t       cur_freq;
	duty_t       cur_duty;
	dead_t       cur_dead;
	logic [9:0]  fstep;
	logic [3:0]  dstep;
	logic [6:0]  tstep;
	logic [20:0] freq_sum;
	logic [7:0]  duty_sum;
	logic [13:0] dead_sum;
	freq_t       freq_up;
	freq_t       freq_dn;
	duty_t       duty_up;
	duty_t       duty_dn;
	dead_t       dead_up;
	dead_t       dead_dn;
	logic        step_up;

	logic        advance;

	// the edit stage moves whenever the result register is free or being drained
	assign advance      = !out_valid_q || settings.ready;
	assign events.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (events.ready) begin
			valid_s1 <= events.valid;
		end
	end

	// payload of the input register
	always_ff @(posedge clk) begin
		if (events.ready && events.valid) begin
			func_s1       <= events.func;
			half_count_s1 <= events.encoder_half_count;
			fine_s1       <= events.fine_key_held;
			coarse_s1     <= events.coarse_key_held;
			preset_s1     <= events.preset_key_held;
		end
	end

	// arithmetic on the active bank
	always_comb begin
		cur_freq = freq_q[bank_q];
		cur_duty = duty_q[bank_q];
		cur_dead = dead_q[bank_q];
		fstep    = freq_step(fine_s1, coarse_s1);
		dstep    = duty_step(fine_s1, coarse_s1);
		tstep    = dead_step(fine_s1, coarse_s1);
		step_up  = half_count_s1 > last_q;

		// saturate on the way up
		freq_sum = {1'b0, cur_freq} + 21'(fstep);
		freq_up  = (freq_sum > 21'(FREQ_MAX)) ? FREQ_MAX : freq_sum[19:0];
		duty_sum = {1'b0, cur_duty} + 8'(dstep);
		duty_up  = (duty_sum > 8'(DUTY_MAX)) ? DUTY_MAX : duty_sum[6:0];
		dead_sum = {1'b0, cur_dead} + 14'(tstep);
		dead_up  = (dead_sum > 14'(DEAD_MAX)) ? DEAD_MAX : dead_sum[12:0];

		// floor on the way down, no wrap below zero
		freq_dn = (cur_freq < (20'(fstep) + FREQ_MIN)) ? FREQ_MIN : cur_freq - 20'(fstep);
		duty_dn = (cur_duty < (7'(dstep) + DUTY_MIN)) ? DUTY_MIN : cur_duty - 7'(dstep);
		// short dead time collapses to zero
		dead_dn = (cur_dead < (13'(tstep) + DEAD_FLOOR)) ? 13'd0 : cur_dead - 13'(tstep);
	end

	// event decode and state update
	always_comb begin
		freq_nxt   = freq_q;
		duty_nxt   = duty_q;
		dead_nxt   = dead_q;
		bank_nxt   = bank_q;
		mode_nxt   = mode_q;
		last_nxt   = last_q;
		reload_nxt = 1'b0;

		unique case (func_s1)
			FUNC_ENCODER: begin
				// same half-count as before means no movement
				if (half_count_s1 != last_q) begin
					unique case (mode_q)
						MODE_FREQ: freq_nxt[bank_q] = step_up ? freq_up : freq_dn;
						MODE_DUTY: duty_nxt[bank_q] = step_up ? duty_up : duty_dn;
						MODE_DEAD: dead_nxt[bank_q] = step_up ? dead_up : dead_dn;
						default: ; // unreachable mode edits nothing
					endcase
					last_nxt   = half_count_s1;
					reload_nxt = 1'b1;
				end
			end
			FUNC_BUTTON: begin
				mode_nxt = (mode_q >= MODE_DEAD) ? MODE_FREQ : mode_q + 2'd1;
				if (preset_s1) begin
					freq_nxt[0] = PRE_FREQ_B0;
					duty_nxt[0] = PRE_DUTY;
					dead_nxt[0] = PRE_DEAD_B0;
					freq_nxt[1] = PRE_FREQ_B1;
					duty_nxt[1] = PRE_DUTY;
					dead_nxt[1] = PRE_DEAD_B1;
					reload_nxt  = 1'b1;
				end
			end
			FUNC_SELECT: begin
				bank_nxt   = !bank_q;
				reload_nxt = 1'b1;
			end
			default: ; // unused event kind reports without change
		endcase
	end

	// state commits when the request leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q[0] <= RST_FREQ_B0;
			freq_q[1] <= RST_FREQ_B1;
			duty_q[0] <= RST_DUTY;
			duty_q[1] <= RST_DUTY;
			dead_q[0] <= RST_DEAD_B0;
			dead_q[1] <= RST_DEAD_B1;
			bank_q    <= 1'b0;
			mode_q    <= MODE_FREQ;
			last_q    <= '0;
		end else if (valid_s1 && advance) begin
			freq_q <= freq_nxt;
			duty_q <= duty_nxt;
			dead_q <= dead_nxt;
			bank_q <= bank_nxt;
			mode_q <= mode_nxt;
			last_q <= last_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_freq_q   <= freq_nxt[bank_nxt];
			out_duty_q   <= duty_nxt[bank_nxt];
			out_dead_q   <= dead_nxt[bank_nxt];
			out_bank_q   <= bank_nxt;
			out_mode_q   <= mode_nxt;
			out_reload_q <= reload_nxt;
		end
	end

	assign settings.valid         = out_valid_q;
	assign settings.out_frequency = out_freq_q;
	assign settings.out_duty      = out_duty_q;
	assign settings.out_dead_time = out_dead_q;
	assign settings.out_bank      = out_bank_q;
	assign settings.out_mode      = out_mode_q;
	assign settings.reload        = out_reload_q;

endmodule
`default_nettype wire

[src/epse_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epse_checker
// port-level checks on the reported settings of the editor
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epse_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  valid,
	input wire                  ready,
	input wire epse_pkg::freq_t frequency,
	input wire epse_pkg::duty_t duty,
	input wire epse_pkg::dead_t dead_time,
	input wire                  bank,
	input wire epse_pkg::mode_t mode,
	input wire                  reload
);
	import epse_pkg::*;

	logic        freq_ok;
	logic        duty_dead_ok;
	logic        mode_ok;
	logic [43:0] payload;

	assign freq_ok      = (frequency >= FREQ_MIN) && (frequency <= FREQ_MAX);
	assign duty_dead_ok = (duty >= DUTY_MIN) && (duty <= DUTY_MAX) && (dead_time <= DEAD_MAX)
		&& ((dead_time == '0) || (dead_time >= DEAD_FLOOR));
	assign mode_ok      = (mode == MODE_FREQ) || (mode == MODE_DUTY) || (mode == MODE_DEAD);
	assign payload      = {frequency, duty, dead_time, bank, mode, reload};

	// frequency never leaves its clamp window
	`EPSE_ASSERT_SAME(a_freq_range, clk, arst_n, valid, freq_ok, "frequency out of range")

	// duty in range and dead time either off or at least the floor
	`EPSE_ASSERT_SAME(a_duty_dead, clk, arst_n, valid, duty_dead_ok, "duty or dead time bad")

	// the mode cycles through three values only
	`EPSE_ASSERT_SAME(a_mode_valid, clk, arst_n, valid, mode_ok, "edit mode left its cycle")

	// a stalled result keeps its contents
	`EPSE_ASSERT_NEXT(a_hold, clk, arst_n, valid && !ready, valid && $stable(payload), "stalled result changed")

endmodule

bind encoder_pwm_setting_editor_core epse_checker u_epse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.valid     (settings.valid),
	.ready     (settings.ready),
	.frequency (settings.out_frequency),
	.duty      (settings.out_duty),
	.dead_time (settings.out_dead_time),
	.bank      (settings.out_bank),
	.mode      (settings.out_mode),
	.reload    (settings.reload)
);
`default_nettype wire

[verif/tb_encoder_pwm_setting_editor_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_encoder_pwm_setting_editor_core
// drives encoder, button, bank select and unused-kind requests through the event channel,
// keeps its own copy of both setting banks, mode and last half-count, and
// checks every reported setting field against the copy in arrival order
// ----------------------------------------------------------------------------
module tb_encoder_pwm_setting_editor_core;
	import epse_pkg::*;

	// event kind that the block must ignore
	localparam func_t FUNC_UNUSED  = 2'd3;
	// cycles with no request and no result taken before giving up
	localparam int    IDLE_LIMIT   = 500;
	// quiet cycles after the last result
	localparam int    DRAIN_CYCLES = 8;
	// requests that do something, directed part and climb included
	localparam int    TARGET_REQS  = 1550;
	// encoder steps of the long frequency climb
	localparam int    CLIMB_STEPS  = 1150;

	typedef struct packed {
		func_t       func;
		half_count_t half_count;
		logic        fine;
		logic        coarse;
		logic        preset;
	} edit_req_t;

	typedef struct packed {
		freq_t freq;
		duty_t duty;
		dead_t dead;
		logic  bank;
		mode_t mode;
		logic  reload;
	} settings_t;

	logic clk = 1'b0;
	logic arst_n;

	epse_in_if  events_if ();
	epse_out_if settings_if ();

	encoder_pwm_setting_editor_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.events   (events_if),
		.settings (settings_if)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// predicted editor state
	// ------------------------------------------------------------------------
	freq_t       bank_freq [2];
	duty_t       bank_duty [2];
	dead_t       bank_dead [2];
	logic        cur_bank;
	mode_t       cur_mode;
	half_count_t last_count;

	settings_t   expected_q [$];
	edit_req_t   pending_q [$];

	// step size for the field under edit, fine wins over coarse
	function automatic int unsigned step_size(input mode_t m, input logic fine,
			input logic coarse);
		case (m)
			MODE_FREQ: return fine ? 10 : (coarse ? 1000 : 100);
			MODE_DUTY: return fine ? 5 : (coarse ? 10 : 1);
			MODE_DEAD: return fine ? 50 : (coarse ? 100 : 5);
			default:   return 0;
		endcase
	endfunction

	function void clear_banks();
		bank_freq[0] = RST_FREQ_B0;
		bank_freq[1] = RST_FREQ_B1;
		bank_duty[0] = RST_DUTY;
		bank_duty[1] = RST_DUTY;
		bank_dead[0] = RST_DEAD_B0;
		bank_dead[1] = RST_DEAD_B1;
		cur_bank     = 1'b0;
		cur_mode     = MODE_FREQ;
		last_count   = '0;
	endfunction

	// applies one request to the predicted state, returns the reported settings
	function settings_t edit_settings(input edit_req_t r);
		int unsigned v;
		int unsigned s;
		logic        up;
		logic        reload;
		settings_t   res;
		reload = 1'b0;
		case (r.func)
			FUNC_ENCODER: begin
				// an unchanged half-count leaves everything alone
				if (r.half_count != last_count) begin
					up = r.half_count > last_count;
					s  = step_size(cur_mode, r.fine, r.coarse);
					case (cur_mode)
						MODE_FREQ: begin
							v = bank_freq[cur_bank];
							if (up)
								v = (v + s > FREQ_MAX) ? FREQ_MAX : v + s;
							else
								v = (v < s + FREQ_MIN) ? FREQ_MIN : v - s;
							bank_freq[cur_bank] = freq_t'(v);
						end
						MODE_DUTY: begin
							v = bank_duty[cur_bank];
							if (up)
								v = (v + s > DUTY_MAX) ? DUTY_MAX : v + s;
							else
								v = (v < s + DUTY_MIN) ? DUTY_MIN : v - s;
							bank_duty[cur_bank] = duty_t'(v);
						end
						MODE_DEAD: begin
							v = bank_dead[cur_bank];
							if (up)
								v = (v + s > DEAD_MAX) ? DEAD_MAX : v + s;
							else
								// short dead times snap to zero
								v = (v < s + DEAD_FLOOR) ? 0 : v - s;
							bank_dead[cur_bank] = dead_t'(v);
						end
						default: ;
					endcase
					last_count = r.half_count;
					reload     = 1'b1;
				end
			end
			FUNC_BUTTON: begin
				cur_mode = (cur_mode >= MODE_DEAD) ? MODE_FREQ : mode_t'(cur_mode + 1);
				// presets overwrite both banks, only then a reload
				if (r.preset) begin
					bank_freq[0] = PRE_FREQ_B0;
					bank_duty[0] = PRE_DUTY;
					bank_dead[0] = PRE_DEAD_B0;
					bank_freq[1] = PRE_FREQ_B1;
					bank_duty[1] = PRE_DUTY;
					bank_dead[1] = PRE_DEAD_B1;
					reload       = 1'b1;
				end
			end
			FUNC_SELECT: begin
				cur_bank = ~cur_bank;
				reload   = 1'b1;
			end
			default: ;
		endcase
		res.freq   = bank_freq[cur_bank];
		res.duty   = bank_duty[cur_bank];
		res.dead   = bank_dead[cur_bank];
		res.bank   = cur_bank;
		res.mode   = cur_mode;
		res.reload = reload;
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// request generation, with its own view of half-count and mode
	// ------------------------------------------------------------------------
	half_count_t gen_count;
	mode_t       gen_mode;
	int          live_reqs;

	task push_req(input func_t f, input half_count_t hc, input logic fine,
			input logic coarse, input logic preset);
		edit_req_t r;
		r.func       = f;
		r.half_count = hc;
		r.fine       = fine;
		r.coarse     = coarse;
		r.preset     = preset;
		pending_q.push_back(r);
		// ignored requests do not count toward the target
		if (f == FUNC_BUTTON || f == FUNC_SELECT || (f == FUNC_ENCODER && hc != gen_count))
			live_reqs++;
		if (f == FUNC_ENCODER)
			gen_count = hc;
		if (f == FUNC_BUTTON)
			gen_mode = (gen_mode >= MODE_DEAD) ? MODE_FREQ : mode_t'(gen_mode + 1);
	endtask

	// one encoder step in the given direction, wrapping the count when it runs out
	task push_turn(input bit up, input logic fine, input logic coarse, input logic preset);
		int d;
		int nxt;
		d = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 60) : $urandom_range(1, 3);
		if (up) begin
			if (gen_count == 8'hFF)
				push_req(FUNC_ENCODER, half_count_t'($urandom_range(0, 3)), fine, coarse,
					preset);
			nxt = int'(gen_count) + d;
			if (nxt > 255)
				nxt = 255;
		end else begin
			if (gen_count == 8'h00)
				push_req(FUNC_ENCODER, half_count_t'($urandom_range(252, 255)), fine,
					coarse, preset);
			nxt = int'(gen_count) - d;
			if (nxt < 0)
				nxt = 0;
		end
		push_req(FUNC_ENCODER, half_count_t'(nxt), fine, coarse, preset);
	endtask

	// button presses until the wanted edit mode, now and then with presets
	task select_mode(input mode_t target);
		while (gen_mode != target)
			push_req(FUNC_BUTTON, half_count_t'($urandom), 1'($urandom), 1'($urandom),
				$urandom_range(0, 7) == 0);
	endtask

	// ------------------------------------------------------------------------
	// request driver: pops pending requests, random gap before each
	// ------------------------------------------------------------------------
	edit_req_t cur_req;
	bit        req_busy;
	bit        req_taken;
	bit        quiet_in;
	int        req_gap;

	always @(negedge clk) begin
		if (arst_n) begin
			if (req_taken) begin
				req_busy  = 1'b0;
				req_taken = 1'b0;
			end
			if (!req_busy) begin
				if (req_gap > 0)
					req_gap--;
				else if (pending_q.size() > 0) begin
					cur_req  = pending_q.pop_front();
					req_busy = 1'b1;
					// occasional stretches with back-to-back requests
					if ($urandom_range(0, 39) == 0)
						quiet_in = ~quiet_in;
					req_gap = quiet_in ? 0 : $urandom_range(0, 4);
				end
			end
			events_if.valid              <= req_busy;
			events_if.func               <= cur_req.func;
			events_if.encoder_half_count <= cur_req.half_count;
			events_if.fine_key_held      <= cur_req.fine;
			events_if.coarse_key_held    <= cur_req.coarse;
			events_if.preset_key_held    <= cur_req.preset;
		end
	end

	// ------------------------------------------------------------------------
	// settings receiver: random stall after each result taken
	// ------------------------------------------------------------------------
	bit res_taken;
	bit quiet_out;
	int res_stall;

	always @(negedge clk) begin
		if (arst_n) begin
			if (res_taken) begin
				res_taken = 1'b0;
				if ($urandom_range(0, 39) == 0)
					quiet_out = ~quiet_out;
				res_stall = quiet_out ? 0 : $urandom_range(0, 4);
			end
			if (res_stall > 0) begin
				res_stall--;
				settings_if.ready <= 1'b0;
			end else
				settings_if.ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------
	int errors;
	int reqs_done;
	int results_seen;
	int idle_cycles;
	int n_reload;
	int hit_freq_max, hit_freq_min, hit_duty_max, hit_duty_min, hit_dead_max, hit_dead_zero;

	task report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at result %0d, %s: got %0d expected %0d", results_seen, what,
			got, want);
		errors++;
	endtask

	task check_settings(input settings_t got, input settings_t want);
		if (got.freq != want.freq)
			report_mismatch("out_frequency", got.freq, want.freq);
		if (got.duty != want.duty)
			report_mismatch("out_duty", got.duty, want.duty);
		if (got.dead != want.dead)
			report_mismatch("out_dead_time", got.dead, want.dead);
		if (got.bank != want.bank)
			report_mismatch("out_bank", got.bank, want.bank);
		if (got.mode != want.mode)
			report_mismatch("out_mode", got.mode, want.mode);
		if (got.reload != want.reload)
			report_mismatch("reload", got.reload, want.reload);
	endtask

	settings_t seen;
	settings_t want;
	edit_req_t taken;

	// outputs sampled at the rising edge, before the block updates them
	always @(posedge clk) begin
		if (arst_n) begin
			if (settings_if.valid && settings_if.ready) begin
				res_taken        = 1'b1;
				seen.freq        = settings_if.out_frequency;
				seen.duty        = settings_if.out_duty;
				seen.dead        = settings_if.out_dead_time;
				seen.bank        = settings_if.out_bank;
				seen.mode        = settings_if.out_mode;
				seen.reload      = settings_if.reload;
				results_seen++;
				if (expected_q.size() == 0)
					report_mismatch("result with nothing expected", seen.freq, 0);
				else
					check_settings(seen, expected_q.pop_front());
			end
			if (events_if.valid && events_if.ready) begin
				req_taken         = 1'b1;
				taken.func        = events_if.func;
				taken.half_count  = events_if.encoder_half_count;
				taken.fine        = events_if.fine_key_held;
				taken.coarse      = events_if.coarse_key_held;
				taken.preset      = events_if.preset_key_held;
				want              = edit_settings(taken);
				expected_q.push_back(want);
				reqs_done++;
				n_reload      += want.reload;
				hit_freq_max  += (want.freq == FREQ_MAX);
				hit_freq_min  += (want.freq == FREQ_MIN);
				hit_duty_max  += (want.duty == DUTY_MAX);
				hit_duty_min  += (want.duty == DUTY_MIN);
				hit_dead_max  += (want.dead == DEAD_MAX);
				hit_dead_zero += (want.dead == 0);
			end
			// watchdog on a stuck handshake
			if ((events_if.valid && events_if.ready) || (settings_if.valid && settings_if.ready))
				idle_cycles = 0;
			else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("watchdog: %0d idle cycles, %0d requests and %0d results taken",
						idle_cycles, reqs_done, results_seen);
					$display("FAIL encoder_pwm_setting_editor_core");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int        total_reqs;
		int        climb_at;
		bit        climbed;
		int        pick;
		int        len;
		int        keys;
		bit        up;
		logic      fine;
		logic      coarse;

		arst_n                       = 1'b0;
		events_if.valid              = 1'b0;
		events_if.func               = FUNC_ENCODER;
		events_if.encoder_half_count = '0;
		events_if.fine_key_held      = 1'b0;
		events_if.coarse_key_held    = 1'b0;
		events_if.preset_key_held    = 1'b0;
		settings_if.ready            = 1'b0;
		clear_banks();
		gen_count = '0;
		gen_mode  = MODE_FREQ;

		// directed: unchanged half-count, then the unused event kind with all bits set
		push_req(FUNC_ENCODER, 8'h00, 1'b0, 1'b0, 1'b0);
		push_req(FUNC_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1);
		// frequency: default up, fine over coarse down, coarse up
		push_req(FUNC_ENCODER, 8'hFF, 1'b0, 1'b0, 1'b1);
		push_req(FUNC_ENCODER, 8'h00, 1'b1, 1'b1, 1'b0);
		push_req(FUNC_ENCODER, 8'h10, 1'b0, 1'b1, 1'b0);
		// button without presets: mode moves, no reload
		push_req(FUNC_BUTTON, 8'h55, 1'b0, 1'b0, 1'b0);
		// duty coarse up into the ceiling
		for (int k = 0; k < 5; k++)
			push_req(FUNC_ENCODER, half_count_t'(8'h20 + 8'h10 * k), 1'b0, 1'b1, 1'b0);
		// other bank, duty coarse down into the floor
		push_req(FUNC_SELECT, 8'hAA, 1'b1, 1'b0, 1'b1);
		for (int k = 0; k < 5; k++)
			push_req(FUNC_ENCODER, half_count_t'(8'h58 - 8'h08 * k), 1'b0, 1'b1, 1'b0);
		// presets load, mode to dead time
		push_req(FUNC_BUTTON, 8'h00, 1'b0, 1'b0, 1'b1);
		// dead time down to zero, up by one step, then snapped back to zero
		push_req(FUNC_ENCODER, 8'h30, 1'b0, 1'b1, 1'b0);
		push_req(FUNC_ENCODER, 8'h28, 1'b0, 1'b1, 1'b0);
		push_req(FUNC_ENCODER, 8'h80, 1'b0, 1'b0, 1'b0);
		push_req(FUNC_ENCODER, 8'h01, 1'b0, 1'b0, 1'b0);
		// mode wraps back to frequency
		push_req(FUNC_BUTTON, 8'h7F, 1'b1, 1'b1, 1'b0);

		// random: bursts of steady turning, bank flips and noise, one long climb
		climb_at = $urandom_range(100, 300);
		climbed  = 1'b0;
		while (live_reqs < TARGET_REQS) begin
			if (!climbed && live_reqs >= climb_at) begin
				climbed = 1'b1;
				select_mode(MODE_FREQ);
				repeat (CLIMB_STEPS)
					push_turn(1'b1, 1'b0, 1'b1, 1'($urandom));
			end
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				select_mode(mode_t'($urandom_range(0, 2)));
				up   = 1'($urandom);
				keys = $urandom_range(0, 3);
				len  = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 100)
					: $urandom_range(1, 40);
				repeat (len) begin
					case (keys)
						0: begin
							fine   = 1'b0;
							coarse = 1'b0;
						end
						1: begin
							fine   = 1'b1;
							coarse = 1'($urandom);
						end
						2: begin
							fine   = 1'b0;
							coarse = 1'b1;
						end
						default: begin
							fine   = 1'($urandom);
							coarse = 1'($urandom);
						end
					endcase
					push_turn(up, fine, coarse, 1'($urandom));
				end
			end else if (pick == 6)
				push_req(FUNC_SELECT, half_count_t'($urandom), 1'($urandom), 1'($urandom),
					1'($urandom));
			else begin
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 3) == 0)
						push_req(FUNC_ENCODER, gen_count, 1'($urandom), 1'($urandom),
							1'($urandom));
					else
						push_req(func_t'($urandom_range(0, 3)), half_count_t'($urandom),
							1'($urandom), 1'($urandom), $urandom_range(0, 5) == 0);
				end
			end
		end
		total_reqs = pending_q.size();

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// all requests in and every expected result back, then a quiet tail
		while (reqs_done < total_reqs || expected_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d requests and %0d results, %0d asking for reload",
			reqs_done, results_seen, n_reload);
		$display("limits seen: freq max %0d min %0d, duty max %0d min %0d, dead max %0d zero %0d",
			hit_freq_max, hit_freq_min, hit_duty_max, hit_duty_min, hit_dead_max, hit_dead_zero);
		if (errors == 0)
			$display("PASS encoder_pwm_setting_editor_core");
		else
			$display("FAIL encoder_pwm_setting_editor_core");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/epse_pkg.sv
src/epse_if.sv
src/encoder_pwm_setting_editor_core.sv
src/epse_checker.sv
verif/tb_encoder_pwm_setting_editor_core.sv
